// File: design/mdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_pkg
// Types, widths and codes shared by the max drawdown tracker modules.
// ----------------------------------------------------------------------------
package mdd_pkg;

  localparam int VAL_W      = 48;
  localparam int IDX_W      = 20;
  localparam int SUM_W      = 64;
  localparam int PCT_W      = 32;
  localparam int DD_OUT_W   = 47;
  localparam int FRAC_BITS  = 16;
  localparam int PCT_SCALE  = 100;
  localparam int DIV_N_W    = 72;
  localparam int DIV_D_W    = 48;
  localparam int DIV_CNT_W  = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [IDX_W-1:0]     IDX_MAX    = {IDX_W{1'b1}};
  localparam logic [DD_OUT_W-1:0]  DD_OUT_MAX = {DD_OUT_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST   = DIV_CNT_W'(DIV_N_W - 1);
  // quotient magnitude at which a percent leaves the signed 32-bit range
  localparam logic [DIV_N_W-1:0]   PCT_LIMIT  = DIV_N_W'(1) << (PCT_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_IS_PNL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CAPITAL = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    end_of_series;
  } in_item_t;

  typedef struct packed {
    logic [DD_OUT_W-1:0]     worst_drawdown;
    logic signed [PCT_W-1:0] worst_drawdown_pct;
    logic [IDX_W-1:0]        peak_at;
    logic [IDX_W-1:0]        trough_at;
    logic [IDX_W-1:0]        recovered_at;
    logic [IDX_W-1:0]        peak_to_trough_bars;
    logic [IDX_W-1:0]        peak_to_recovery_bars;
    logic [DD_OUT_W-1:0]     mean_drawdown;
    logic signed [PCT_W-1:0] mean_drawdown_pct;
    logic [IDX_W-1:0]        underwater_total;
  } out_item_t;

  // series totals carried with every bar record
  typedef struct packed {
    logic [VAL_W-1:0] best_dd;
    logic [IDX_W-1:0] best_peak_at;
    logic [IDX_W-1:0] best_trough_at;
    logic             rec_seen;
    logic [IDX_W-1:0] rec_at;
    logic [SUM_W-1:0] dd_sum;
    logic [IDX_W-1:0] uw_bars;
  } snap_t;

  typedef struct packed {
    logic                    uw;
    logic                    new_best;
    logic                    last;
    logic [VAL_W-1:0]        dd;
    logic signed [VAL_W-1:0] peak;
    snap_t                   snap;
  } bar_rec_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

endpackage

// File: design/mdd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_front
// Takes bars, tracks equity, peak, worst drawdown and sums, queues bar records.
// ----------------------------------------------------------------------------
module mdd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  mdd_pkg::in_item_t                 in_item,
  output logic                              full,
  input  logic                              cfg_we,
  input  logic [mdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mdd_pkg::VAL_W-1:0]         cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output mdd_pkg::bar_rec_t                 q_data
);
  import mdd_pkg::*;

  logic                    input_is_pnl;
  logic signed [VAL_W-1:0] start_capital;

  logic [IDX_W-1:0]        bar_index;
  logic signed [VAL_W-1:0] equity;
  logic signed [VAL_W-1:0] peak;
  logic [IDX_W-1:0]        peak_at;
  logic [VAL_W-1:0]        best_dd;
  logic [IDX_W-1:0]        best_peak_at;
  logic signed [VAL_W-1:0] best_peak_value;
  logic [IDX_W-1:0]        best_trough_at;
  logic                    rec_seen;
  logic [IDX_W-1:0]        rec_at;
  logic [SUM_W-1:0]        dd_sum;
  logic [IDX_W-1:0]        uw_bars;

  logic [IDX_W-1:0]        bar_index_next;
  logic signed [VAL_W-1:0] equity_next;
  logic signed [VAL_W-1:0] peak_next;
  logic [IDX_W-1:0]        peak_at_next;
  logic [VAL_W-1:0]        best_dd_next;
  logic [IDX_W-1:0]        best_peak_at_next;
  logic signed [VAL_W-1:0] best_peak_value_next;
  logic [IDX_W-1:0]        best_trough_at_next;
  logic                    rec_seen_next;
  logic [IDX_W-1:0]        rec_at_next;
  logic [SUM_W-1:0]        dd_sum_next;
  logic [IDX_W-1:0]        uw_bars_next;

  logic                    first, compare, uw, new_best, accept;
  logic [IDX_W-1:0]        i;
  logic signed [VAL_W-1:0] eq0, pk0, cur, sample;
  logic signed [VAL_W:0]   wide_sum;
  logic [VAL_W:0]          wide_dd;
  logic [VAL_W-1:0]        dd;
  logic [SUM_W:0]          sum_wide;

  assign sample = in_item.sample_value;
  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    first    = (bar_index == '0);
    compare  = !first || input_is_pnl;
    i        = first ? (input_is_pnl ? IDX_W'(1) : '0) : bar_index;
    eq0      = first ? (input_is_pnl ? start_capital : sample) : equity;
    pk0      = first ? (input_is_pnl ? start_capital : sample) : peak;

    wide_sum = {eq0[VAL_W-1], eq0} + {sample[VAL_W-1], sample};
    if (wide_sum[VAL_W] != wide_sum[VAL_W-1]) begin
      cur = wide_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      cur = wide_sum[VAL_W-1:0];
    end
    if (!input_is_pnl) begin
      cur = sample;
    end

    wide_dd  = {pk0[VAL_W-1], pk0} - {cur[VAL_W-1], cur};
    dd       = wide_dd[VAL_W-1:0];
    sum_wide = {1'b0, dd_sum} + (SUM_W+1)'(dd);

    equity_next          = eq0;
    peak_next            = pk0;
    peak_at_next         = first ? '0 : peak_at;
    best_dd_next         = best_dd;
    best_peak_at_next    = best_peak_at;
    best_peak_value_next = best_peak_value;
    best_trough_at_next  = best_trough_at;
    rec_seen_next        = rec_seen;
    rec_at_next          = rec_at;
    dd_sum_next          = dd_sum;
    uw_bars_next         = uw_bars;
    uw                   = 1'b0;
    new_best             = 1'b0;

    if (compare) begin
      equity_next = cur;
      if (best_dd != '0 && !rec_seen && cur >= best_peak_value) begin
        rec_seen_next = 1'b1;
        rec_at_next   = i;
      end
      if (cur >= pk0) begin
        peak_next    = cur;
        peak_at_next = i;
      end else begin
        uw           = 1'b1;
        dd_sum_next  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        uw_bars_next = (uw_bars != IDX_MAX) ? uw_bars + 1'b1 : IDX_MAX;
        if (dd > best_dd) begin
          new_best             = 1'b1;
          best_dd_next         = dd;
          best_peak_at_next    = peak_at_next;
          best_peak_value_next = pk0;
          best_trough_at_next  = i;
          rec_seen_next        = 1'b0;
          rec_at_next          = '0;
        end
      end
    end
    bar_index_next = (i != IDX_MAX) ? i + 1'b1 : IDX_MAX;
  end

  always_comb begin
    q_data                     = '0;
    q_data.uw                  = uw;
    q_data.new_best            = new_best;
    q_data.last                = in_item.end_of_series;
    q_data.dd                  = dd;
    q_data.peak                = pk0;
    q_data.snap.best_dd        = best_dd_next;
    q_data.snap.best_peak_at   = best_peak_at_next;
    q_data.snap.best_trough_at = best_trough_at_next;
    q_data.snap.rec_seen       = rec_seen_next;
    q_data.snap.rec_at         = rec_at_next;
    q_data.snap.dd_sum         = dd_sum_next;
    q_data.snap.uw_bars        = uw_bars_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_is_pnl  <= 1'b0;
      start_capital <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_IS_PNL:  input_is_pnl  <= cfg_data[0];
        CFG_START_CAPITAL: start_capital <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_item.end_of_series)) begin
      bar_index       <= '0;
      equity          <= '0;
      peak            <= '0;
      peak_at         <= '0;
      best_dd         <= '0;
      best_peak_at    <= '0;
      best_peak_value <= '0;
      best_trough_at  <= '0;
      rec_seen        <= 1'b0;
      rec_at          <= '0;
      dd_sum          <= '0;
      uw_bars         <= '0;
    end else if (accept) begin
      bar_index       <= bar_index_next;
      equity          <= equity_next;
      peak            <= peak_next;
      peak_at         <= peak_at_next;
      best_dd         <= best_dd_next;
      best_peak_at    <= best_peak_at_next;
      best_peak_value <= best_peak_value_next;
      best_trough_at  <= best_trough_at_next;
      rec_seen        <= rec_seen_next;
      rec_at          <= rec_at_next;
      dd_sum          <= dd_sum_next;
      uw_bars         <= uw_bars_next;
    end
  end

  a_trough_after_peak: assert property (@(posedge clk) disable iff (rst)
    (best_dd != '0) |-> (best_trough_at >= best_peak_at))
    else $error("worst trough precedes its peak");

  a_recovery_after_trough: assert property (@(posedge clk) disable iff (rst)
    rec_seen |-> (rec_at >= best_trough_at && best_dd != '0))
    else $error("recovery without a drawdown before it");

endmodule

// File: design/mdd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_fifo
// Two-entry queue of bar records between front and back.
// ----------------------------------------------------------------------------
module mdd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mdd_pkg::bar_rec_t wdata,
  output logic              full,
  input  logic              pop,
  output mdd_pkg::bar_rec_t rdata,
  output logic              empty
);
  import mdd_pkg::*;

  bar_rec_t    slots [2];
  logic        wptr, rptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= 2'd2) && ((count == 2'd0 || count == 2'd2) == (wptr == rptr)))
    else $error("queue pointers disagree with fill count");

endmodule

// File: design/mdd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mdd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  mdd_pkg::div_req_t             req,
  output logic                          busy,
  output logic                          done,
  output logic [mdd_pkg::DIV_N_W-1:0]   quot
);
  import mdd_pkg::*;

  logic [DIV_N_W-1:0]   nq;
  logic [DIV_D_W:0]     rem;
  logic [DIV_D_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W:0]     rem_sh;
  logic                 take;

  assign quot   = nq;
  assign rem_sh = {rem[DIV_D_W-1:0], nq[DIV_N_W-1]};
  assign take   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq  <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? rem_sh - {1'b0, dvs} : rem_sh;
      nq  <= {nq[DIV_N_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/mdd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdd_back
// Drains bar records: percent of peak, percent sums, means, summary register.
// ----------------------------------------------------------------------------
module mdd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mdd_pkg::bar_rec_t   q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output mdd_pkg::out_item_t  out_item
);
  import mdd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PCT  = 6'b000010,
    S_ACC  = 6'b000100,
    S_MDD  = 6'b001000,
    S_MPCT = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                  state;
  bar_rec_t                rec;
  logic signed [PCT_W-1:0] pct;
  logic signed [PCT_W-1:0] best_pct;
  logic signed [SUM_W-1:0] pct_sum;
  logic [DD_OUT_W-1:0]     mean_dd;
  logic signed [PCT_W-1:0] mean_pct;
  logic                    out_valid;

  div_req_t                div_req;
  logic                    div_busy, div_done;
  logic [DIV_N_W-1:0]      quot;

  logic [VAL_W-1:0]        peak_mag;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SUM_W:0]   acc_wide;
  logic signed [PCT_W-1:0] pct_q;
  logic signed [PCT_W-1:0] mpct_q;
  logic                    slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == S_IDLE) && !q_empty;

  assign peak_mag = q_data.peak[VAL_W-1] ? VAL_W'(-q_data.peak) : VAL_W'(q_data.peak);
  assign sum_mag  = pct_sum[SUM_W-1] ? SUM_W'(-pct_sum) : SUM_W'(pct_sum);
  assign acc_wide = {pct_sum[SUM_W-1], pct_sum} + (SUM_W+1)'(pct);

  always_comb begin
    // clamp quotient magnitude to the signed 32-bit range, sign of the peak for pct_q, of the percent sum for mpct_q
    if (!rec.peak[VAL_W-1]) begin
      pct_q = (quot >= PCT_LIMIT) ? {1'b0, {(PCT_W-1){1'b1}}} : PCT_W'(quot);
    end else begin
      pct_q = (quot >= PCT_LIMIT) ? {1'b1, {(PCT_W-1){1'b0}}} : PCT_W'(-quot);
    end
    if (!pct_sum[SUM_W-1]) begin
      mpct_q = (quot >= PCT_LIMIT) ? {1'b0, {(PCT_W-1){1'b1}}} : PCT_W'(quot);
    end else begin
      mpct_q = (quot >= PCT_LIMIT) ? {1'b1, {(PCT_W-1){1'b0}}} : PCT_W'(-quot);
    end
  end

  always_comb begin
    div_req = '0;
    unique case (state)
      S_IDLE: begin
        div_req.start    = !q_empty && q_data.uw && (q_data.peak != '0);
        div_req.dividend = (DIV_N_W'(q_data.dd) << FRAC_BITS) * DIV_N_W'(PCT_SCALE);
        div_req.divisor  = peak_mag;
      end
      S_ACC: begin
        div_req.start    = rec.last && (rec.snap.uw_bars != '0);
        div_req.dividend = DIV_N_W'(rec.snap.dd_sum);
        div_req.divisor  = DIV_D_W'(rec.snap.uw_bars);
      end
      S_MDD: begin
        div_req.start    = div_done;
        div_req.dividend = DIV_N_W'(sum_mag);
        div_req.divisor  = DIV_D_W'(rec.snap.uw_bars);
      end
      default: ;
    endcase
  end

  mdd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pct       <= '0;
      best_pct  <= '0;
      pct_sum   <= '0;
      mean_dd   <= '0;
      mean_pct  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && !(state == S_EMIT && slot_free)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            pct   <= '0;
            state <= (q_data.uw && q_data.peak != '0) ? S_PCT : S_ACC;
          end
        end
        S_PCT: begin
          if (div_done) begin
            pct   <= pct_q;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (rec.uw) begin
            if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
              pct_sum <= acc_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
              pct_sum <= acc_wide[SUM_W-1:0];
            end
            if (rec.new_best) best_pct <= pct;
          end
          if (!rec.last) begin
            state <= S_IDLE;
          end else if (rec.snap.uw_bars != '0) begin
            state <= S_MDD;
          end else begin
            mean_dd  <= '0;
            mean_pct <= '0;
            state    <= S_EMIT;
          end
        end
        S_MDD: begin
          if (div_done) begin
            mean_dd <= (quot > DIV_N_W'(DD_OUT_MAX)) ? DD_OUT_MAX : quot[DD_OUT_W-1:0];
            state   <= S_MPCT;
          end
        end
        S_MPCT: begin
          if (div_done) begin
            mean_pct <= mpct_q;
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            best_pct  <= '0;
            pct_sum   <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && slot_free) begin
      out_item.worst_drawdown <= (rec.snap.best_dd > VAL_W'(DD_OUT_MAX))
                                 ? DD_OUT_MAX : rec.snap.best_dd[DD_OUT_W-1:0];
      out_item.worst_drawdown_pct    <= best_pct;
      out_item.peak_at               <= rec.snap.best_peak_at;
      out_item.trough_at             <= rec.snap.best_trough_at;
      out_item.recovered_at          <= rec.snap.rec_seen ? rec.snap.rec_at : '0;
      out_item.peak_to_trough_bars   <= rec.snap.best_trough_at - rec.snap.best_peak_at;
      out_item.peak_to_recovery_bars <= rec.snap.rec_seen
                                        ? rec.snap.rec_at - rec.snap.best_peak_at : '0;
      out_item.mean_drawdown         <= mean_dd;
      out_item.mean_drawdown_pct     <= mean_pct;
      out_item.underwater_total      <= rec.snap.uw_bars;
    end
  end

  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCT || state == S_MPCT) |-> (div_busy || div_done))
    else $error("waiting on a divider that is not running");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// File: design/max_drawdown_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_drawdown_tracker_core
// Streaming maximum drawdown analysis with one summary per series.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  bars in   push / full        in_item  (sample_value, end_of_series)
//  summary   pop / empty        out_item (ten summary fields)
//  config    cfg_we             cfg_index, cfg_data
//
//  The front takes one bar per cycle into a two-entry queue while it is not full.
//  The back passes a bar at or above its peak or at a zero peak through S_IDLE and S_ACC,
//  and on an underwater bar runs the 72-step divider in S_PCT between the two.
//  The last bar of a series with underwater bars adds two more divider runs
//  and the summary write.
//  Reset (rst, synchronous) clears all series state and both registers.
//  A summary not popped holds the back; a full queue holds push.
// ----------------------------------------------------------------------------
module max_drawdown_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  mdd_pkg::in_item_t             in_item,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output mdd_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [mdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdd_pkg::VAL_W-1:0]     cfg_data
);
  import mdd_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  bar_rec_t q_wdata, q_rdata;

  mdd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  mdd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mdd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: tb/max_drawdown_tracker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_drawdown_tracker_core_test
// Drives series of bars through the drawdown tracker in equity and pnl modes
// and compares every summary with an in-bench prediction of the series.
// ----------------------------------------------------------------------------
module max_drawdown_tracker_core_test;
  import mdd_pkg::*;

  localparam longint VHI        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VLO        = -64'sh0000_8000_0000_0000;
  localparam int     BAR_CAP    = 1048575;
  localparam int     HOLD_LEN   = 3000;
  localparam int     DOG_LIMIT  = 20000;
  localparam int     DRAIN_WAIT = 400;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  in_item_t           in_item = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  out_item_t          out_item;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]   cfg_data = '0;

  max_drawdown_tracker_core dut (
    .clk(clk), .rst(rst), .push(push), .in_item(in_item), .full(full),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copies and series state of the predictor
  bit              pnl_mode;
  longint          capital;
  int unsigned     bar_no;
  longint          equity, peak;
  int unsigned     peak_bar;
  longint unsigned worst_dd;
  longint          worst_pct;
  int unsigned     worst_peak_bar, worst_trough_bar;
  longint          worst_peak_val;
  bit              recovered;
  int unsigned     recovery_bar;
  longint unsigned dd_total;
  longint          pct_total;
  int unsigned     uw_bars;

  in_item_t  bar_q[$];
  out_item_t summary_q[$];
  int        errors = 0;
  bit        idle_on = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        hold_go = 1'b0;
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        dog = 0;

  function automatic longint clamp48(longint v);
    if (v > VHI) return VHI;
    if (v < VLO) return VLO;
    return v;
  endfunction

  function automatic longint pct_of_peak(longint unsigned dd, longint pk);
    logic [127:0] num, mag, q;
    if (pk == 0) return 0;
    mag = (pk < 0) ? 128'(longint'(-pk)) : 128'(pk);
    num = (128'(dd) * 128'd100) << FRAC_BITS;
    q = num / mag;
    if (q > 128'hFFFF_FFFF) q = 128'h1_0000_0000;
    if (pk > 0) return (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q[63:0]);
    return (q > 128'h8000_0000) ? -64'sh8000_0000 : -longint'(q[63:0]);
  endfunction

  function automatic logic [IDX_W-1:0] idx_sat(int unsigned v);
    return (v > BAR_CAP) ? IDX_MAX : v[IDX_W-1:0];
  endfunction

  function automatic void clear_series();
    bar_no = 0; equity = 0; peak = 0; peak_bar = 0;
    worst_dd = 0; worst_pct = 0; worst_peak_bar = 0; worst_peak_val = 0;
    worst_trough_bar = 0; recovered = 0; recovery_bar = 0;
    dd_total = 0; pct_total = 0; uw_bars = 0;
  endfunction

  // advance the series by one bar; queue a summary on the last bar
  function automatic void track_bar(in_item_t it);
    longint          v, cur, p, mp;
    longint unsigned dd, m;
    bit              cmp;
    int unsigned     i;
    out_item_t       s;
    v = longint'(it.sample_value);
    cmp = 1'b1;
    if (bar_no == 0) begin
      if (pnl_mode) begin
        equity = capital; peak = capital; peak_bar = 0; bar_no = 1;
      end else begin
        equity = v; peak = v; peak_bar = 0; cmp = 1'b0;
      end
    end
    i = bar_no;
    if (cmp) begin
      cur = pnl_mode ? clamp48(equity + v) : v;
      equity = cur;
      if (worst_dd > 0 && !recovered && cur >= worst_peak_val) begin
        recovered = 1'b1; recovery_bar = i;
      end
      if (cur >= peak) begin
        peak = cur; peak_bar = i;
      end else begin
        dd = longint'(peak - cur);
        p = pct_of_peak(dd, peak);
        dd_total = (dd_total > 64'hFFFF_FFFF_FFFF_FFFF - dd) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                              : dd_total + dd;
        if (p > 0 && pct_total > 64'sh7FFF_FFFF_FFFF_FFFF - p)
          pct_total = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (p < 0 && pct_total < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - p)
          pct_total = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else
          pct_total = pct_total + p;
        if (uw_bars < BAR_CAP) uw_bars++;
        if (dd > worst_dd) begin
          worst_dd = dd; worst_pct = p; worst_peak_bar = peak_bar;
          worst_peak_val = peak; worst_trough_bar = i;
          recovered = 1'b0; recovery_bar = 0;
        end
      end
    end
    bar_no = (i < BAR_CAP) ? i + 1 : BAR_CAP;
    if (!it.end_of_series) return;
    s.worst_drawdown = (worst_dd > 64'(DD_OUT_MAX)) ? DD_OUT_MAX : worst_dd[DD_OUT_W-1:0];
    s.worst_drawdown_pct = worst_pct[PCT_W-1:0];
    s.peak_at = idx_sat(worst_peak_bar);
    s.trough_at = idx_sat(worst_trough_bar);
    s.recovered_at = recovered ? idx_sat(recovery_bar) : '0;
    s.peak_to_trough_bars = idx_sat(worst_trough_bar - worst_peak_bar);
    s.peak_to_recovery_bars = recovered ? idx_sat(recovery_bar - worst_peak_bar) : '0;
    if (uw_bars > 0) begin
      m = dd_total / longint'(uw_bars);
      mp = pct_total / longint'(uw_bars);
      if (mp > 64'sh7FFF_FFFF) mp = 64'sh7FFF_FFFF;
      if (mp < -64'sh8000_0000) mp = -64'sh8000_0000;
      s.mean_drawdown = (m > 64'(DD_OUT_MAX)) ? DD_OUT_MAX : m[DD_OUT_W-1:0];
      s.mean_drawdown_pct = mp[PCT_W-1:0];
    end else begin
      s.mean_drawdown = '0;
      s.mean_drawdown_pct = '0;
    end
    s.underwater_total = idx_sat(uw_bars);
    summary_q.insert(summary_q.size(), s);
    clear_series();
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic check_summary(out_item_t got);
    out_item_t w;
    if (summary_q.size() == 0) begin
      report("unexpected summary", 64'(got.worst_drawdown), 0);
      return;
    end
    w = summary_q.pop_front();
    if (got.worst_drawdown !== w.worst_drawdown)
      report("worst_drawdown", 64'(got.worst_drawdown), 64'(w.worst_drawdown));
    if (got.worst_drawdown_pct !== w.worst_drawdown_pct)
      report("worst_drawdown_pct", 64'(got.worst_drawdown_pct), 64'(w.worst_drawdown_pct));
    if (got.peak_at !== w.peak_at)
      report("peak_at", 64'(got.peak_at), 64'(w.peak_at));
    if (got.trough_at !== w.trough_at)
      report("trough_at", 64'(got.trough_at), 64'(w.trough_at));
    if (got.recovered_at !== w.recovered_at)
      report("recovered_at", 64'(got.recovered_at), 64'(w.recovered_at));
    if (got.peak_to_trough_bars !== w.peak_to_trough_bars)
      report("peak_to_trough_bars", 64'(got.peak_to_trough_bars),
             64'(w.peak_to_trough_bars));
    if (got.peak_to_recovery_bars !== w.peak_to_recovery_bars)
      report("peak_to_recovery_bars", 64'(got.peak_to_recovery_bars),
             64'(w.peak_to_recovery_bars));
    if (got.mean_drawdown !== w.mean_drawdown)
      report("mean_drawdown", 64'(got.mean_drawdown), 64'(w.mean_drawdown));
    if (got.mean_drawdown_pct !== w.mean_drawdown_pct)
      report("mean_drawdown_pct", 64'(got.mean_drawdown_pct), 64'(w.mean_drawdown_pct));
    if (got.underwater_total !== w.underwater_total)
      report("underwater_total", 64'(got.underwater_total), 64'(w.underwater_total));
  endtask

  // driver: predict on acceptance, then offer the next request after its gap
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) track_bar(in_item);
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        push <= 1'b0;
      end else if (bar_q.size() > 0) begin
        in_item <= bar_q.pop_front();
        push <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 9) : 0;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here so the input side backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        check_summary(out_item);
        recv_gap <= idle_on ? $urandom_range(0, 9) : 0;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= (hold_left == 0) && !(hold_go && !hold_done);
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || rst) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("max_drawdown_tracker_core_test NOT OK");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_INPUT_IS_PNL) pnl_mode = val[0];
    else capital = longint'($signed(val));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic bar(longint v, bit last);
    in_item_t it;
    it.sample_value = v[VAL_W-1:0];
    it.end_of_series = last;
    bar_q.insert(bar_q.size(), it);
  endtask

  function automatic longint rand_mag(longint unsigned scale);
    longint unsigned u;
    longint r;
    u = {$urandom, $urandom};
    r = longint'(u % (scale + 1));
    return $urandom_range(0, 1) ? -r : r;
  endfunction

  task automatic random_series(int len);
    longint          lvl, v;
    longint unsigned scale;
    int              style;
    style = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: scale = 4;
      1: scale = 64'd1 << 18;
      2: scale = 64'd1 << 32;
      default: scale = 64'd1 << 45;
    endcase
    lvl = rand_mag(scale * 4);
    for (int k = 0; k < len; k++) begin
      if (style < 7) begin
        v = rand_mag(scale);
        if (!pnl_mode) begin
          lvl = clamp48(lvl + v);
          v = lvl;
        end
      end else if (style < 9) begin
        v = longint'($signed({$urandom, $urandom}) <<< 16) >>> 16;
      end else begin
        v = longint'(int'($urandom_range(0, 4)) - 2);
      end
      bar(v, k == len - 1);
    end
  endtask

  task automatic drain();
    while (bar_q.size() > 0 || push || summary_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_random(int bars);
    int sent;
    sent = 0;
    while (sent < bars) begin
      int len;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
      random_series(len);
      sent += len;
    end
  endtask

  initial begin
    pnl_mode = 0;
    capital = 0;
    clear_series();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // equity mode, directed
    write_reg(CFG_INPUT_IS_PNL, '0);
    write_reg(CFG_START_CAPITAL, '0);
    bar(5 << 16, 1);
    bar(1, 0); bar(2, 0); bar(3, 1);
    bar(0, 0); bar(-65536, 0); bar(0, 1);
    bar(-100 << 16, 0); bar(-200 << 16, 1);
    bar(VHI, 0); bar(VLO, 1);
    bar(VLO, 0); bar(VHI, 1);
    bar(10, 0); bar(4, 0); bar(10, 0); bar(2, 0); bar(11, 0); bar(3, 1);
    idle_on = 1'b1;
    run_random(280);
    drain();

    // pnl mode from the top of the range; hold the summary side meanwhile
    write_reg(CFG_INPUT_IS_PNL, 48'd1);
    write_reg(CFG_START_CAPITAL, VHI[VAL_W-1:0]);
    bar(5, 0); bar(-3, 1);
    hold_go <= 1'b1;
    run_random(300);
    drain();

    // pnl mode from the bottom of the range
    idle_on = 1'b0;
    write_reg(CFG_START_CAPITAL, VLO[VAL_W-1:0]);
    bar(-5, 1); bar(1, 1);
    run_random(300);
    drain();

    idle_on = 1'b1;
    write_reg(CFG_START_CAPITAL, 48'(1000 << 16));
    run_random(350);
    drain();

    write_reg(CFG_START_CAPITAL, 48'({$urandom, $urandom}));
    run_random(350);
    drain();

    write_reg(CFG_INPUT_IS_PNL, '0);
    write_reg(CFG_START_CAPITAL, 48'({$urandom, $urandom}));
    run_random(350);
    drain();

    if (errors == 0) begin
      $display("max_drawdown_tracker_core_test OK");
    end else begin
      $display("max_drawdown_tracker_core_test NOT OK");
    end
    $finish;
  end

endmodule
